FILE: rtl/core/fsfct_pkg.sv
// ---------------------------------------------------------------------------
// Free-chunk table package
// Types and constants shared by the free-chunk table search block.
// ---------------------------------------------------------------------------
package fsfct_pkg;

   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned SIZE_W   = 32;
   localparam int unsigned INDEX_W  = 6;
   localparam int unsigned USED_W   = 7;
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned WIDE_W   = 13;
   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 80;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND = 3'd0,
      MODE_ERASE  = 3'd1,
      MODE_FIND   = 3'd2,
      MODE_FIRST  = 3'd3,
      MODE_BEST   = 3'd4,
      MODE_WORST  = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_ERASE,
      S_SCAN,
      S_RESOLVE,
      S_SHRINK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } entry_type;

endpackage

FILE: rtl/core/fit_search_free_chunk_table.sv
// ---------------------------------------------------------------------------
// Free-chunk table with first, best and worst fit
// Ordered table of chunks held in one synchronous memory and walked by a
// small sequencer, one entry per cycle.
// ---------------------------------------------------------------------------
// An item is accepted only once the previous result has been loaded, so
// the block takes no new item before it is through with the last one. A
// fit that splits a chunk writes the remainder and then shrinks the entry.
// The walk is set by the single read port of the entry memory. Reset
// empties the table at once; the memory is not cleared.
// ---------------------------------------------------------------------------
module fit_search_free_chunk_table
   import fsfct_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // chunk_address [31:0], chunk_size [63:32], entry_index [69:64], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode [2:0]
   input  logic [MODE_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // found_index [5:0], found_address [37:6], found_size [69:38],
   // entries_used [76:70], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [STATUS_W-1:0]   rsp_tuser
);

   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   // The table itself: one entry per chunk, read data registered.
   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic [IDX_W-1:0] mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] rd_addr_ff, rd_addr_in;

   // Captured request.
   mode_type          mode_ff, mode_in;
   logic [ADDR_W-1:0] req_addr_ff, req_addr_in;
   logic [SIZE_W-1:0] req_size_ff, req_size_in;
   logic [INDEX_W-1:0] req_index_ff, req_index_in;

   // Best candidate of a walk, or the matched entry.
   logic              pick_valid_ff, pick_valid_in;
   logic [IDX_W-1:0]  pick_idx_ff, pick_idx_in;
   entry_type         pick_ff, pick_in;
   entry_type         removed_ff, removed_in;

   // Result waiting for the output register.
   status_type        res_status_ff, res_status_in;
   logic [IDX_W-1:0]  res_idx_ff, res_idx_in;
   entry_type         res_ff, res_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   entry_type         rsp_entry_ff, rsp_entry_in;
   logic [USED_W-1:0] rsp_used_ff, rsp_used_in;

   logic req_fire;
   logic slot_free;
   logic full;
   logic more;
   logic is_first;
   logic hit;
   logic take;
   logic split;

   assign req_fire  = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign more      = (CNT_W'(rd_addr_ff) + CNT_W'(1)) < count_ff;
   assign is_first  = (rd_addr_ff == IDX_W'(req_index_ff));
   assign split     = pick_ff.size > req_size_ff;

   // Compare of the entry that has just come out of the memory.
   always_comb begin
      hit  = 1'b0;
      take = 1'b0;
      case (mode_ff)
         MODE_FIND: begin
            hit = (rd_data_ff.addr == req_addr_ff);
         end
         MODE_FIRST: begin
            hit = (rd_data_ff.size >= req_size_ff);
         end
         MODE_BEST: begin
            hit  = (rd_data_ff.size == req_size_ff);
            take = (rd_data_ff.size > req_size_ff)
                   && (!pick_valid_ff || rd_data_ff.size < pick_ff.size);
         end
         MODE_WORST: begin
            take = (rd_data_ff.size >= req_size_ff)
                   && (!pick_valid_ff || rd_data_ff.size > pick_ff.size);
         end
         default: begin
            hit  = 1'b0;
            take = 1'b0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_START;
            end
         end
         S_START: begin
            case (mode_ff)
               MODE_ERASE: begin
                  state_in = (WIDE_W'(req_index_ff) >= WIDE_W'(count_ff)) ? S_RESP : S_ERASE;
               end
               MODE_FIND, MODE_FIRST, MODE_BEST, MODE_WORST: begin
                  state_in = (count_ff == '0) ? S_RESP : S_SCAN;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_ERASE: begin
            if (!more) begin
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            if (hit) begin
               state_in = S_RESOLVE;
            end else if (!more) begin
               state_in = (pick_valid_ff || take) ? S_RESOLVE : S_RESP;
            end
         end
         S_RESOLVE: begin
            state_in = (mode_ff != MODE_FIND && split && !full) ? S_SHRINK : S_RESP;
         end
         S_SHRINK: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      req_tready    = (state_ff == S_IDLE) && !reset;
      count_in      = count_ff;
      rd_addr_in    = rd_addr_ff;
      mode_in       = mode_ff;
      req_addr_in   = req_addr_ff;
      req_size_in   = req_size_ff;
      req_index_in  = req_index_ff;
      pick_valid_in = pick_valid_ff;
      pick_idx_in   = pick_idx_ff;
      pick_in       = pick_ff;
      removed_in    = removed_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_used_in   = rsp_used_ff;
      mem_we        = 1'b0;
      mem_waddr     = IDX_W'(count_ff);
      mem_wdata     = '{addr: req_addr_ff, size: req_size_ff};
      mem_raddr     = rd_addr_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in      = mode_type'(req_tuser);
               req_addr_in  = req_tdata[ADDR_W-1:0];
               req_size_in  = req_tdata[ADDR_W+SIZE_W-1:ADDR_W];
               req_index_in = req_tdata[ADDR_W+SIZE_W+INDEX_W-1:ADDR_W+SIZE_W];
            end
         end
         S_START: begin
            pick_valid_in = 1'b0;
            res_status_in = ST_NOT_FOUND;
            res_idx_in    = '0;
            res_in        = '0;
            case (mode_ff)
               MODE_APPEND: begin
                  if (full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mem_we        = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     res_status_in = ST_OK;
                     res_idx_in    = IDX_W'(count_ff);
                     res_in        = '{addr: req_addr_ff, size: req_size_ff};
                  end
               end
               MODE_ERASE: begin
                  if (WIDE_W'(req_index_ff) >= WIDE_W'(count_ff)) begin
                     res_status_in = ST_BAD_INDEX;
                  end else begin
                     mem_raddr  = IDX_W'(req_index_ff);
                     rd_addr_in = IDX_W'(req_index_ff);
                  end
               end
               MODE_FIND, MODE_FIRST, MODE_BEST, MODE_WORST: begin
                  mem_raddr  = '0;
                  rd_addr_in = '0;
               end
               default: begin
                  res_status_in = ST_NOT_FOUND;
               end
            endcase
         end
         S_ERASE: begin
            if (is_first) begin
               removed_in = rd_data_ff;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = rd_addr_ff - IDX_W'(1);
               mem_wdata = rd_data_ff;
            end
            if (more) begin
               mem_raddr  = rd_addr_ff + IDX_W'(1);
               rd_addr_in = rd_addr_ff + IDX_W'(1);
            end else begin
               count_in      = count_ff - CNT_W'(1);
               res_status_in = ST_OK;
               res_idx_in    = IDX_W'(req_index_ff);
               res_in        = is_first ? rd_data_ff : removed_ff;
            end
         end
         S_SCAN: begin
            if (hit || take) begin
               pick_valid_in = 1'b1;
               pick_idx_in   = rd_addr_ff;
               pick_in       = rd_data_ff;
            end
            if (!hit && more) begin
               mem_raddr  = rd_addr_ff + IDX_W'(1);
               rd_addr_in = rd_addr_ff + IDX_W'(1);
            end
         end
         S_RESOLVE: begin
            res_status_in = ST_OK;
            res_idx_in    = pick_idx_ff;
            res_in        = pick_ff;
            if (mode_ff != MODE_FIND && split) begin
               if (full) begin
                  res_status_in = ST_FULL;
                  res_idx_in    = '0;
                  res_in        = '0;
               end else begin
                  // Remainder goes to the end of the table.
                  mem_we    = 1'b1;
                  mem_wdata = '{addr: pick_ff.addr + req_size_ff,
                                size: pick_ff.size - req_size_ff};
                  count_in  = count_ff + CNT_W'(1);
                  res_in    = '{addr: pick_ff.addr, size: req_size_ff};
               end
            end
         end
         S_SHRINK: begin
            mem_we    = 1'b1;
            mem_waddr = pick_idx_ff;
            mem_wdata = '{addr: pick_ff.addr, size: req_size_ff};
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = INDEX_W'(res_idx_ff);
               rsp_entry_in  = res_ff;
               rsp_used_in   = USED_W'(count_ff);
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      mode_ff       <= mode_in;
      req_addr_ff   <= req_addr_in;
      req_size_ff   <= req_size_in;
      req_index_ff  <= req_index_in;
      pick_valid_ff <= pick_valid_in;
      pick_idx_ff   <= pick_idx_in;
      pick_ff       <= pick_in;
      removed_ff    <= removed_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_used_ff, rsp_entry_ff.size, rsp_entry_ff.addr, rsp_idx_ff};

   // The table never holds more entries than it has room for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // An accepted item always starts the sequencer.
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_START)
      else $error("accepted item did not start");

   // Leaving the result state always presents a result.
   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && slot_free) |=> rsp_valid_ff)
      else $error("result not presented");

   // A successful append grows the table by one.
   a_append_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START && mode_ff == MODE_APPEND && !full)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not grow the table");

endmodule
